@@ rtl/core/dhfc_pkg.sv @@
// Shared types and constants for the double/half float converter.
// No dependencies; used by every module under rtl/core.
package dhfc_pkg;

  localparam int unsigned DBL_W = 64;

  localparam logic [10:0] DBL_EXP_ONES = 11'h7ff;
  localparam logic [4:0] HALF_EXP_ONES = 5'h1f;
  localparam logic [10:0] EXP_SHIFT = 11'd1008;
  localparam logic [10:0] SUB_EXP_BASE = 11'd1009;
  localparam logic [10:0] NARROW_OVF_EXP = 11'd1039;
  localparam logic [10:0] NARROW_MIN_EXP = 11'd998;
  localparam logic [10:0] SUB_SHIFT_BASE = 11'd1051;
  localparam logic [14:0] HALF_INF = 15'h7c00;
  localparam logic [9:0] HALF_QUIET = 10'h200;

  typedef enum logic [0:0] {
    CMD_NARROW = 1'b0,
    CMD_WIDEN  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [DBL_W-1:0] result;
    logic             exact;
  } conv_t;

endpackage

@@ rtl/core/dhfc_narrow.sv @@
// Binary64 to binary16 narrowing with round to nearest even and exactness flag.
// Depends on dhfc_pkg.
module dhfc_narrow (
  input  logic [63:0]   value,
  output dhfc_pkg::conv_t conv
);

  logic        sgn;
  logic [10:0] e;
  logic [51:0] m;
  logic [52:0] full;
  logic [5:0]  sh;
  logic [5:0]  sh_m1;
  logic [52:0] fr;
  logic [52:0] sticky_mask;
  logic        rb_sub;
  logic        st_sub;
  logic [10:0] q_sub;
  logic [10:0] q_sub_r;
  logic [4:0]  he;
  logic [14:0] q_nrm;
  logic [14:0] q_nrm_r;
  logic        st_nrm;
  logic [15:0] half;
  logic        exact;

  always_comb begin
    sgn = value[63];
    e = value[62:52];
    m = value[51:0];
    full = {1'b1, m};

    sh = 6'(SUB_SHIFT_BASE_SUB(e));
    sh_m1 = sh - 6'd1;
    fr = full >> sh_m1;
    rb_sub = fr[0];
    q_sub = fr[11:1];
    sticky_mask = (53'd1 << sh_m1) - 53'd1;
    st_sub = |(full & sticky_mask);
    q_sub_r = q_sub + 11'(rb_sub && (st_sub || q_sub[0]));

    he = 5'(e - dhfc_pkg::EXP_SHIFT);
    q_nrm = {he, m[51:42]};
    st_nrm = |m[40:0];
    q_nrm_r = q_nrm + 15'(m[41] && (st_nrm || q_nrm[0]));

    priority if (e == dhfc_pkg::DBL_EXP_ONES) begin
      half = {sgn, dhfc_pkg::HALF_EXP_ONES,
              m[51:42] | ((m != 52'd0) ? dhfc_pkg::HALF_QUIET : 10'd0)};
      exact = (m[41:0] == 42'd0) && ((m == 52'd0) || m[51]);
    end else if (e >= dhfc_pkg::NARROW_OVF_EXP) begin
      half = {sgn, dhfc_pkg::HALF_INF};
      exact = 1'b0;
    end else if (e >= dhfc_pkg::SUB_EXP_BASE) begin
      half = {sgn, q_nrm_r};
      exact = !m[41] && !st_nrm;
    end else if (e >= dhfc_pkg::NARROW_MIN_EXP) begin
      half = {sgn, 4'd0, q_sub_r};
      exact = !rb_sub && !st_sub;
    end else begin
      half = {sgn, 15'd0};
      exact = (e == 11'd0) && (m == 52'd0);
    end

    conv.result = {48'd0, half};
    conv.exact = exact;
  end

  function automatic logic [10:0] SUB_SHIFT_BASE_SUB(input logic [10:0] ex);
    return dhfc_pkg::SUB_SHIFT_BASE - ex;
  endfunction

endmodule

@@ rtl/core/dhfc_widen.sv @@
// Binary16 to binary64 widening, exact, with subnormal normalization.
// Depends on dhfc_pkg.
module dhfc_widen (
  input  logic [15:0]   half,
  output dhfc_pkg::conv_t conv
);

  logic        sgn;
  logic [4:0]  e;
  logic [9:0]  m;
  logic [3:0]  top;
  logic [3:0]  k;
  logic [9:0]  m_norm;
  logic [63:0] dbl;

  always_comb begin
    sgn = half[15];
    e = half[14:10];
    m = half[9:0];

    top = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        top = 4'(i);
      end
    end
    k = 4'd10 - top;
    m_norm = 10'({1'b0, m} << k);

    priority if (e == 5'd0) begin
      if (m == 10'd0) begin
        dbl = {sgn, 63'd0};
      end else begin
        dbl = {sgn, dhfc_pkg::SUB_EXP_BASE - 11'(k), m_norm, 42'd0};
      end
    end else if (e == dhfc_pkg::HALF_EXP_ONES) begin
      dbl = {sgn, dhfc_pkg::DBL_EXP_ONES, m, 42'd0};
    end else begin
      dbl = {sgn, 11'(e) + dhfc_pkg::EXP_SHIFT, m, 42'd0};
    end

    conv.result = dbl;
    conv.exact = 1'b1;
  end

endmodule

@@ rtl/core/double_half_float_converter.sv @@
// Top level of the double/half float converter: input register, conversion
// logic, result register. Depends on dhfc_pkg, dhfc_narrow and dhfc_widen.
//
// Usage:
//   Slave stream s_*: s_tdata carries the 64-bit value, s_tuser the command
//   (0 narrow binary64 to binary16, 1 widen binary16 in bits 15..0).
//   Master stream m_*: m_tdata carries the result (half in bits 15..0 when
//   narrowing, upper bits zero), m_tuser the exact flag (narrowed half
//   widens back to the same 64 bits; always 1 when widening).
//   Path from input transfer to result valid: input register, then result
//   register. Throughput: one item per cycle while the receiver does not
//   stall, set by the single-pass conversion logic between the two registers.
//   Reset (rst, synchronous) empties both registers; no result is pending.
//   Receiver stall: the result register holds; the input register still
//   takes an item while it is empty, then s_tready drops until m_tready
//   returns. No item is lost or repeated.
module double_half_float_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic [0:0]  s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] result
  output logic [0:0]  m_tuser    // [0] exact
);

  logic            in_valid;
  logic [63:0]     in_value;
  dhfc_pkg::cmd_t  in_cmd;
  dhfc_pkg::conv_t narrow_conv;
  dhfc_pkg::conv_t widen_conv;
  dhfc_pkg::conv_t sel_conv;
  dhfc_pkg::conv_t out_conv;
  logic            out_valid;
  logic            out_stall;
  logic            advance;

  assign out_stall = out_valid && !m_tready;
  assign advance = !out_stall;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_value <= s_tdata;
      in_cmd <= dhfc_pkg::cmd_t'(s_tuser[0]);
    end
  end

  dhfc_narrow u_narrow (
    .value (in_value),
    .conv  (narrow_conv)
  );

  dhfc_widen u_widen (
    .half (in_value[15:0]),
    .conv (widen_conv)
  );

  always_comb begin
    unique case (in_cmd)
      dhfc_pkg::CMD_NARROW: sel_conv = narrow_conv;
      dhfc_pkg::CMD_WIDEN:  sel_conv = widen_conv;
      default:              sel_conv = narrow_conv;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_conv <= sel_conv;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = out_conv.result;
  assign m_tuser = out_conv.exact;

endmodule
